// ===== sv/ebd_pkg.sv =====
// Shared types, code tables and constants for the EAN-8 bar decoder.
package ebd_pkg;

   localparam int HEAD_W   = 31;
   localparam int TAIL_W   = 36;
   localparam int SYM_W    = 7;
   localparam int NUM_SYM  = 8;
   localparam int HALF_SYM = 4;
   localparam int NUM_CODE = 10;

   localparam logic [2:0] GUARD_EDGE = 3'b101;
   localparam logic [4:0] GUARD_MID  = 5'b01010;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_START     = 3'd1,
      ST_MIDDLE    = 3'd2,
      ST_END       = 3'd3,
      ST_LEFT_SYM  = 3'd4,
      ST_RIGHT_SYM = 3'd5
   } status_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] digit;
   } lane_res_type;

   typedef logic [SYM_W-1:0] code_table_type [NUM_CODE];

   localparam code_table_type L_CODES = '{
      7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
   };

   localparam code_table_type R_CODES = '{
      7'h72, 7'h66, 7'h6C, 7'h42, 7'h5C, 7'h4E, 7'h50, 7'h44, 7'h48, 7'h74
   };

endpackage

// ===== sv/ebd_lane.sv =====
// One symbol lane: matches a 7-module symbol against the L or R code set.
module ebd_lane #(
   parameter bit IS_RIGHT = 1'b0
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [ebd_pkg::SYM_W-1:0]   sym,
   output ebd_pkg::lane_res_type       res
);
   import ebd_pkg::*;

   lane_res_type res_ff;
   lane_res_type res_in;

   always_comb begin
      res_in = '0;
      for (int d = 0; d < NUM_CODE; d++) begin
         if ((IS_RIGHT ? R_CODES[d] : L_CODES[d]) == sym) begin
            res_in.hit   = 1'b1;
            res_in.digit = 4'(d);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ===== sv/ebd_merge.sv =====
// Merge stage: folds the guard result and lane matches into digits, status and check flag.
module ebd_merge (
   input  logic                       clock,
   input  logic                       enable,
   input  ebd_pkg::status_type        guard_status,
   input  ebd_pkg::lane_res_type      lanes [ebd_pkg::NUM_SYM],
   output logic [31:0]                digits,
   output ebd_pkg::status_type        status,
   output logic                       check_ok
);
   import ebd_pkg::*;

   logic         left_fail;
   logic         right_fail;
   status_type   status_in;
   status_type   status_ff;
   logic [31:0]  digits_in;
   logic [31:0]  digits_ff;
   logic         check_in;
   logic         check_ff;
   logic [7:0]   sum;
   logic [15:0]  prod;
   logic [4:0]   quot;
   logic [7:0]   rem_wide;
   logic [3:0]   rem;
   logic [3:0]   expect_dig;
   logic [31:0]  packed_dig;

   always_comb begin
      left_fail  = 1'b0;
      right_fail = 1'b0;
      packed_dig = '0;
      for (int i = 0; i < HALF_SYM; i++) begin
         left_fail  = left_fail | ~lanes[i].hit;
         right_fail = right_fail | ~lanes[HALF_SYM + i].hit;
      end
      for (int i = 0; i < NUM_SYM; i++) begin
         packed_dig[31 - 4*i -: 4] = lanes[i].digit;
      end
   end

   // Weighted sum: odd positions (first, third, ...) count three times.
   always_comb begin
      sum = 8'(3 * (8'(lanes[0].digit) + 8'(lanes[2].digit)
                  + 8'(lanes[4].digit) + 8'(lanes[6].digit)))
          + 8'(lanes[1].digit) + 8'(lanes[3].digit) + 8'(lanes[5].digit);
      // Division by ten through the reciprocal 205/2048, exact for every 8-bit sum.
      prod       = 16'(sum) * 16'd205;
      quot       = prod[15:11];
      rem_wide   = sum - {quot, 3'b000} - {2'b00, quot, 1'b0};
      rem        = rem_wide[3:0];
      expect_dig = (rem == 4'd0) ? 4'd0 : 4'd10 - rem;
   end

   always_comb begin
      if (guard_status != ST_OK) begin
         status_in = guard_status;
      end else if (left_fail) begin
         status_in = ST_LEFT_SYM;
      end else if (right_fail) begin
         status_in = ST_RIGHT_SYM;
      end else begin
         status_in = ST_OK;
      end
      digits_in = (status_in == ST_OK) ? packed_dig : '0;
      check_in  = (status_in == ST_OK) && (lanes[NUM_SYM-1].digit == expect_dig);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         status_ff <= status_in;
         digits_ff <= digits_in;
         check_ff  <= check_in;
      end
   end

   assign digits   = digits_ff;
   assign status   = status_ff;
   assign check_ok = check_ff;

endmodule

// ===== sv/ean8_bar_decoder.sv =====
// Top level of the EAN-8 bar decoder: guard check, eight symbol lanes and merge stage.
// Usage:
// One request beat carries a complete 67-module pattern: modules_head holds
// modules 0 to 30 and modules_tail modules 31 to 66, first module in the MSB.
// One response beat follows for every request beat, in order, with eight BCD
// digits (first digit in the top nibble), a status code and the check flag.
// A failed guard or symbol gives a nonzero status and zero digits.
// From request acceptance to rsp_valid a beat passes the two registered stages:
// the eight symbol lanes and the guard check register in the first stage, the
// merge stage builds digits, status and the mod-10 check in the second.
// Throughput is one pattern per cycle; the pipeline moves whenever the
// response register is empty or is being taken.
// When the receiver stalls, the whole two-stage pipeline holds and req_ready
// falls, so nothing is lost; req_ready follows rsp_ready combinationally.
// Reset clears both stage valid bits; the data registers are not reset.
module ean8_bar_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ebd_pkg::HEAD_W-1:0]    req_modules_head,
   input  logic [ebd_pkg::TAIL_W-1:0]    req_modules_tail,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [31:0]                   rsp_digits,
   output logic [2:0]                    rsp_status,
   output logic                          rsp_check_ok
);
   import ebd_pkg::*;

   logic          advance;
   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   status_type    guard_ff;
   status_type    guard_in;
   status_type    status;
   lane_res_type  lanes [NUM_SYM];

   assign advance   = ~out_valid_ff | rsp_ready;
   assign req_ready = advance;

   always_comb begin
      if (req_modules_head[30:28] != GUARD_EDGE) begin
         guard_in = ST_START;
      end else if (req_modules_tail[35:31] != GUARD_MID) begin
         guard_in = ST_MIDDLE;
      end else if (req_modules_tail[2:0] != GUARD_EDGE) begin
         guard_in = ST_END;
      end else begin
         guard_in = ST_OK;
      end
   end

   for (genvar g = 0; g < HALF_SYM; g++) begin : g_lanes
      ebd_lane #(.IS_RIGHT(1'b0)) u_left (
         .clock  (clock),
         .enable (advance),
         .sym    (req_modules_head[27 - SYM_W*g -: SYM_W]),
         .res    (lanes[g])
      );
      ebd_lane #(.IS_RIGHT(1'b1)) u_right (
         .clock  (clock),
         .enable (advance),
         .sym    (req_modules_tail[30 - SYM_W*g -: SYM_W]),
         .res    (lanes[HALF_SYM + g])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         guard_ff <= guard_in;
      end
   end

   ebd_merge u_merge (
      .clock        (clock),
      .enable       (advance),
      .guard_status (guard_ff),
      .lanes        (lanes),
      .digits       (rsp_digits),
      .status       (status),
      .check_ok     (rsp_check_ok)
   );

   assign s1_valid_in  = advance ? req_valid : s1_valid_ff;
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = status;

   // A failed pattern never shows digits.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_digits == '0))
      else $error("failed pattern with nonzero digits");

   // The check flag is only raised for a fully decoded pattern.
   a_check_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_check_ok |-> (rsp_status == ST_OK))
      else $error("check flag set on a failed pattern");

   // An accepted request always occupies the first stage on the next cycle.
   a_stage_fill: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted beat lost before the merge stage");

   // A full first stage moves into the response register when the pipeline advances.
   a_stage_move: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance |=> rsp_valid)
      else $error("first-stage beat lost on advance");

endmodule

// ===== tb/sv/ean8_bar_decoder_tb.sv =====
// Self-checking testbench for the EAN-8 bar pattern decoder.
`timescale 1ns / 1ps

module ean8_bar_decoder_tb;
   import ebd_pkg::*;

   localparam int          CYCLE_LIMIT  = 300000;
   localparam int          RANDOM_BEATS = 1000;
   localparam int          CALM_BEATS   = 200;
   localparam int          MAX_PRINTS   = 100;
   localparam logic [2:0]  EDGE_GUARD   = 3'b101;
   localparam logic [4:0]  CENTER_GUARD = 5'b01010;

   localparam logic [6:0] LEFT_SET [10] = '{
      7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
   };
   localparam logic [6:0] RIGHT_SET [10] = '{
      7'h72, 7'h66, 7'h6C, 7'h42, 7'h5C, 7'h4E, 7'h50, 7'h44, 7'h48, 7'h74
   };

   typedef struct packed {
      logic [31:0] digits;
      status_type  status;
      logic        check_ok;
   } scan_res_type;

   typedef struct packed {
      logic [30:0]  head;
      logic [35:0]  tail;
      logic         typed;
      scan_res_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [30:0] req_modules_head = '0;
   logic [35:0] req_modules_tail = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digits;
   logic [2:0]  rsp_status;
   logic        rsp_check_ok;

   // Expectation that rides along with the beat currently on the request port.
   logic         beat_typed = 1'b0;
   scan_res_type beat_want = '0;
   logic         calm = 1'b0;

   scan_res_type expected_scans [$];
   stim_row_type directed_rows [$];
   int           error_count = 0;
   int           cycle_count = 0;

   ean8_bar_decoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_modules_head (req_modules_head),
      .req_modules_tail (req_modules_tail),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digits       (rsp_digits),
      .rsp_status       (rsp_status),
      .rsp_check_ok     (rsp_check_ok)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int code_index(input logic right_half, input logic [6:0] sym);
      int d;
      for (d = 0; d < 10; d++) begin
         if ((right_half ? RIGHT_SET[d] : LEFT_SET[d]) == sym) begin
            return d;
         end
      end
      return 10;
   endfunction

   // Weighted 3-1 check digit over the first seven BCD digits.
   function automatic logic [3:0] check_digit_of(input logic [31:0] bcd);
      int sum;
      int i;
      sum = 0;
      for (i = 0; i < 7; i++) begin
         sum += ((i % 2) == 0 ? 3 : 1) * int'(bcd[31-4*i -: 4]);
      end
      return 4'((10 - (sum % 10)) % 10);
   endfunction

   function automatic scan_res_type decode_scan(input logic [30:0] head, input logic [35:0] tail);
      scan_res_type r;
      int           d;
      int           i;
      logic [6:0]   sym;
      r = '{digits: '0, status: ST_OK, check_ok: 1'b0};
      if (head[30:28] != EDGE_GUARD) begin
         r.status = ST_START;
      end else if (tail[35:31] != CENTER_GUARD) begin
         r.status = ST_MIDDLE;
      end else if (tail[2:0] != EDGE_GUARD) begin
         r.status = ST_END;
      end else begin
         for (i = 0; i < 8; i++) begin
            sym = (i < 4) ? head[27-7*i -: 7] : tail[30-7*(i-4) -: 7];
            d = code_index(i >= 4, sym);
            if (d > 9) begin
               if (r.status == ST_OK) begin
                  r.status = (i < 4) ? ST_LEFT_SYM : ST_RIGHT_SYM;
               end
            end else begin
               r.digits[31-4*i -: 4] = 4'(d);
            end
         end
      end
      if (r.status == ST_OK) begin
         r.check_ok = (r.digits[3:0] == check_digit_of(r.digits));
      end else begin
         r.digits = '0;
      end
      return r;
   endfunction

   // Builds the 67-module pattern {head, tail} for eight valid BCD digits.
   function automatic logic [66:0] encode_bcd(input logic [31:0] bcd);
      logic [66:0] pat;
      int          i;
      pat = '0;
      pat[66:64] = EDGE_GUARD;
      pat[35:31] = CENTER_GUARD;
      pat[2:0]   = EDGE_GUARD;
      for (i = 0; i < 4; i++) begin
         pat[63-7*i -: 7] = LEFT_SET[bcd[31-4*i -: 4]];
         pat[30-7*i -: 7] = RIGHT_SET[bcd[15-4*i -: 4]];
      end
      return pat;
   endfunction

   function automatic void add_row(input logic [66:0] pat, input logic typed,
                                   input logic [31:0] digits, input status_type status,
                                   input logic check_ok);
      stim_row_type row;
      row.head  = pat[66:36];
      row.tail  = pat[35:0];
      row.typed = typed;
      row.want  = '{digits: digits, status: status, check_ok: check_ok};
      directed_rows.push_back(row);
   endfunction

   function automatic void load_directed_rows();
      logic [66:0] good;
      logic [66:0] pat;
      good = encode_bcd(32'h96385074);
      add_row('0, 1'b1, '0, ST_START, 1'b0);
      add_row('1, 1'b1, '0, ST_START, 1'b0);
      add_row(good, 1'b1, 32'h96385074, ST_OK, 1'b1);
      add_row(encode_bcd(32'h96385075), 1'b1, 32'h96385075, ST_OK, 1'b0);
      add_row(encode_bcd(32'h00000000), 1'b1, 32'h00000000, ST_OK, 1'b1);
      add_row(encode_bcd(32'h99999999), 1'b1, 32'h99999999, ST_OK, 1'b0);
      add_row(encode_bcd(32'h12345670), 1'b1, 32'h12345670, ST_OK, 1'b1);
      add_row(encode_bcd(32'h65432109), 1'b0, '0, ST_OK, 1'b0);
      add_row(encode_bcd(32'h80808080), 1'b0, '0, ST_OK, 1'b0);
      add_row(encode_bcd(32'h77889966), 1'b0, '0, ST_OK, 1'b0);
      pat = good; pat[66] = ~pat[66];
      add_row(pat, 1'b1, '0, ST_START, 1'b0);
      pat = good; pat[64] = ~pat[64];
      add_row(pat, 1'b1, '0, ST_START, 1'b0);
      pat = good; pat[33] = ~pat[33];
      add_row(pat, 1'b1, '0, ST_MIDDLE, 1'b0);
      pat = good; pat[0] = ~pat[0];
      add_row(pat, 1'b1, '0, ST_END, 1'b0);
      pat = good; pat[2] = ~pat[2];
      add_row(pat, 1'b1, '0, ST_END, 1'b0);
      pat = good; pat[63:57] = 7'h00;
      add_row(pat, 1'b1, '0, ST_LEFT_SYM, 1'b0);
      // A right-hand code sitting in a left position must not match.
      pat = good; pat[42:36] = RIGHT_SET[0];
      add_row(pat, 1'b1, '0, ST_LEFT_SYM, 1'b0);
      pat = good; pat[30:24] = LEFT_SET[0];
      add_row(pat, 1'b1, '0, ST_RIGHT_SYM, 1'b0);
      pat = good; pat[9:3] = 7'h7F;
      add_row(pat, 1'b1, '0, ST_RIGHT_SYM, 1'b0);
      // Several faults at once: the earliest test in the check order wins.
      pat = good; pat[66] = ~pat[66]; pat[33] = ~pat[33];
      add_row(pat, 1'b1, '0, ST_START, 1'b0);
      pat = good; pat[33] = ~pat[33]; pat[0] = ~pat[0];
      add_row(pat, 1'b1, '0, ST_MIDDLE, 1'b0);
      pat = good; pat[0] = ~pat[0]; pat[63:57] = 7'h00;
      add_row(pat, 1'b1, '0, ST_END, 1'b0);
      pat = good; pat[49:43] = 7'h7F; pat[23:17] = 7'h00;
      add_row(pat, 1'b1, '0, ST_LEFT_SYM, 1'b0);
   endfunction

   // Mostly well-formed scans with random digits, mixed with damaged scans and raw noise.
   function automatic stim_row_type random_row();
      stim_row_type row;
      logic [31:0]  bcd;
      logic [66:0]  pat;
      int           kind;
      int           k;
      int           i;
      bcd = '0;
      for (i = 0; i < 7; i++) begin
         bcd[31-4*i -: 4] = 4'($urandom_range(0, 9));
      end
      bcd[3:0] = ($urandom_range(0, 1) == 1) ? check_digit_of(bcd) : 4'($urandom_range(0, 9));
      pat  = encode_bcd(bcd);
      kind = $urandom_range(0, 99);
      if (kind >= 90) begin
         pat = 67'({$urandom, $urandom, $urandom});
      end else if (kind >= 80) begin
         pat[$urandom_range(0, 66)] ^= 1'b1;
      end else if (kind >= 70) begin
         k = $urandom_range(0, 7);
         if (k < 4) begin
            pat[63-7*k -: 7] = 7'($urandom_range(0, 127));
         end else begin
            pat[30-7*(k-4) -: 7] = 7'($urandom_range(0, 127));
         end
      end
      row.head  = pat[66:36];
      row.tail  = pat[35:0];
      row.typed = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
      end
   endtask

   task automatic drive_beat(input stim_row_type row);
      if (!calm && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_modules_head <= row.head;
      req_modules_tail <= row.tail;
      beat_typed       <= row.typed;
      beat_want        <= row.want;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
   endtask

   // Drains pending results with the sender quiet.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_scans.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 8);
   end

   always @(posedge clock) begin
      scan_res_type want;
      if (!reset) begin
         if (req_valid && req_ready === 1'b1) begin
            expected_scans.push_back(beat_typed ? beat_want
                                     : decode_scan(req_modules_head, req_modules_tail));
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_scans.size() == 0) begin
               report_mismatch("unexpected response beat, digits", rsp_digits, '0);
            end else begin
               want = expected_scans.pop_front();
               if (rsp_digits !== want.digits) begin
                  report_mismatch("digits", rsp_digits, want.digits);
               end
               if (rsp_status !== want.status) begin
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               end
               if (rsp_check_ok !== want.check_ok) begin
                  report_mismatch("check_ok", 32'(rsp_check_ok), 32'(want.check_ok));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int n;
      load_directed_rows();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < directed_rows.size(); n++) begin
         drive_beat(directed_rows[n]);
      end
      hold_until_drained();

      // The first stretch of random beats runs with both sides at full rate.
      calm <= 1'b1;
      for (n = 0; n < RANDOM_BEATS; n++) begin
         if (n == CALM_BEATS) begin
            calm <= 1'b0;
         end
         if (n == RANDOM_BEATS / 2) begin
            hold_until_drained();
         end
         drive_beat(random_row());
      end

      hold_until_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
